// ===== rtl/core/sio_pkg.sv =====
`default_nettype none

package sio_pkg;

  localparam int FRAC_BITS = 30;
  localparam int CH_W      = 4;
  localparam int CHANNELS  = 2 ** CH_W;
  localparam int WORD_W    = 32;
  localparam int PHASE_W   = FRAC_BITS + 4;
  localparam int CALC_W    = PHASE_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [CALC_W-1:0] ONE_FX = CALC_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_SOFT_SYNC   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase;
    logic signed [WORD_W-1:0]  offset;
    logic                      reversed;
  } chan_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/synced_impulse_oscillator.sv =====
// Each word registers into stage s1, then its result into the output register.
// Throughput: one word per cycle unless out_ready stalls; channel state is read
// at accept, written back as the word leaves s1, bypassed for same-channel pairs.
// Reset: synchronous; clears config, pipeline valids and per-channel valid bits,
// so every channel reads as zero phase, zero offset, forward direction.
`default_nettype none

module synced_impulse_oscillator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sio_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic                                cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [sio_pkg::CH_W-1:0]            channel,
  input  wire logic signed [sio_pkg::WORD_W-1:0]   increment,
  input  wire logic signed [sio_pkg::WORD_W-1:0]   offset,
  input  wire logic signed [sio_pkg::WORD_W-1:0]   sync_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [sio_pkg::CH_W-1:0]                 out_channel,
  output logic                                     impulse
);

  localparam int CW = sio_pkg::CALC_W;
  localparam int FB = sio_pkg::FRAC_BITS;

  logic soft_sync;
  logic sync_enable;

  sio_pkg::chan_state_t mem [sio_pkg::CHANNELS];
  logic [sio_pkg::CHANNELS-1:0] ent_valid;
  sio_pkg::chan_state_t rd_data;
  logic rd_hit;

  logic                              s1_valid;
  logic [sio_pkg::CH_W-1:0]          s1_ch;
  logic signed [sio_pkg::WORD_W-1:0] s1_step;
  logic signed [sio_pkg::WORD_W-1:0] s1_offset;
  logic signed [sio_pkg::WORD_W-1:0] s1_sync;

  logic                     lw_valid;
  logic [sio_pkg::CH_W-1:0] lw_ch;
  sio_pkg::chan_state_t     lw_data;

  logic out_free;
  logic accept;
  logic wr_en;

  sio_pkg::chan_state_t cur;
  sio_pkg::chan_state_t nxt;
  logic signed [CW-1:0] ph, diff, dev, step_c, raw_c, sync_c, a, a_dev;
  logic [FB-1:0]        low;
  logic                 synced, imp;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !s1_valid || out_free;
  assign accept    = in_valid && in_ready;
  assign wr_en     = s1_valid && out_free;

  always_comb begin
    if (lw_valid && lw_ch == s1_ch) begin
      cur = lw_data;
    end else if (rd_hit) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end

    raw_c  = CW'(s1_step);
    sync_c = CW'(s1_sync);
    ph     = CW'(cur.phase);

    if (raw_c > sio_pkg::ONE_FX) begin
      step_c = sio_pkg::ONE_FX;
    end else if (raw_c < -sio_pkg::ONE_FX) begin
      step_c = -sio_pkg::ONE_FX;
    end else begin
      step_c = raw_c;
    end
    if (soft_sync && cur.reversed) begin
      step_c = -step_c;
    end

    diff = CW'(s1_offset) - CW'(cur.offset);
    low  = diff[FB-1:0];
    if (diff[CW-1] && low != '0) begin
      dev = {{(CW-FB){1'b0}}, low} - sio_pkg::ONE_FX;
    end else begin
      dev = {{(CW-FB){1'b0}}, low};
    end

    synced = sync_enable && sync_c > CW'(0) && sync_c <= sio_pkg::ONE_FX;
    a_dev  = ph + dev;
    a      = ph;
    if (synced && !soft_sync) begin
      a = sync_c;
    end

    if (!s1_step[sio_pkg::WORD_W-1]) begin
      if (!synced) begin
        a = a_dev;
        if (dev != '0 && a <= CW'(0)) begin
          a = a + sio_pkg::ONE_FX;
        end
      end
      imp = a >= sio_pkg::ONE_FX;
      if (imp) begin
        a = a - sio_pkg::ONE_FX;
      end
    end else begin
      if (synced && a == sio_pkg::ONE_FX) begin
        a = '0;
      end
      if (!synced) begin
        a = a_dev;
        if (a >= sio_pkg::ONE_FX) begin
          a = a - sio_pkg::ONE_FX;
        end
      end
      imp = a <= CW'(0);
      if (imp) begin
        a = a + sio_pkg::ONE_FX;
      end
    end

    a = a + step_c;

    nxt.phase    = a[sio_pkg::PHASE_W-1:0];
    nxt.offset   = s1_offset;
    nxt.reversed = cur.reversed ^ (synced && soft_sync);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_ch] <= nxt;
    end
    if (accept) begin
      rd_data <= mem[channel];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch     <= channel;
      s1_step   <= increment;
      s1_offset <= offset;
      s1_sync   <= sync_value;
    end
    if (wr_en) begin
      lw_ch       <= s1_ch;
      lw_data     <= nxt;
      out_channel <= s1_ch;
      impulse     <= imp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_sync   <= 1'b0;
      sync_enable <= 1'b0;
      ent_valid   <= '0;
      rd_hit      <= 1'b0;
      s1_valid    <= 1'b0;
      lw_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sio_pkg::REG_SOFT_SYNC:   soft_sync   <= cfg_data;
          sio_pkg::REG_SYNC_ENABLE: sync_enable <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        rd_hit <= ent_valid[channel];
      end
      if (wr_en) begin
        ent_valid[s1_ch] <= 1'b1;
        lw_valid         <= 1'b1;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire
